### rtl/yuv420_quad_to_rgb888_macros.svh
// assertion macros shared by the checker
`ifndef YUV420_QUAD_TO_RGB888_MACROS_SVH
`define YUV420_QUAD_TO_RGB888_MACROS_SVH

// same-cycle implication
`define YQR_ASSERT_NOW(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define YQR_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/yqr_pkg.sv
package yqr_pkg;

	localparam int PIX_W    = 8;
	// offsets span -226..222
	localparam int OFFSET_W = 10;
	// luma plus offset spans -226..477
	localparam int SUM_W    = 11;
	localparam int QUAD_N   = 4;
	localparam logic [PIX_W-1:0] PIXEL_MAX = 8'd255;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] red;
		logic signed [OFFSET_W-1:0] green;
		logic signed [OFFSET_W-1:0] blue;
	} offsets_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
	} rgb_t;

endpackage

### rtl/yuv420_quad_to_rgb888.sv
// channel | handshake                | payload
// --------+--------------------------+--------------------------------------
// in      | in_valid / in_stall      | four luma bytes, chroma_blue, chroma_red
// out     | out_valid / out_stall    | red/green/blue for each of four pixels
//
// one quad per cycle sustained while out_stall stays low; each quad passes through
// the input register and then the result register around the offset/clamp logic
// arst_n low empties both stages at once; payload registers are not reset
// out_stall holds the result register; the input register keeps taking a quad
// while it is empty or can move forward, so in_stall rises only when both are full
module yuv420_quad_to_rgb888 import yqr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  pix_t luma_top_left,
	input  pix_t luma_top_right,
	input  pix_t luma_bottom_left,
	input  pix_t luma_bottom_right,
	input  pix_t chroma_blue,
	input  pix_t chroma_red,
	output logic out_valid,
	input  logic out_stall,
	output pix_t red_top_left,
	output pix_t green_top_left,
	output pix_t blue_top_left,
	output pix_t red_top_right,
	output pix_t green_top_right,
	output pix_t blue_top_right,
	output pix_t red_bottom_left,
	output pix_t green_bottom_left,
	output pix_t blue_bottom_left,
	output pix_t red_bottom_right,
	output pix_t green_bottom_right,
	output pix_t blue_bottom_right
);

	logic     valid_s1;
	logic     valid_s2;
	pix_t     luma_s1 [QUAD_N];
	pix_t     cb_s1;
	pix_t     cr_s1;
	rgb_t     rgb_s2 [QUAD_N];
	rgb_t     rgb_next [QUAD_N];
	offsets_t offsets;
	logic     adv_s1;
	logic     adv_s2;

	// stage advance
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			luma_s1[0] <= luma_top_left;
			luma_s1[1] <= luma_top_right;
			luma_s1[2] <= luma_bottom_left;
			luma_s1[3] <= luma_bottom_right;
			cb_s1      <= chroma_blue;
			cr_s1      <= chroma_red;
		end
	end

	// shared chroma offsets
	yqr_offset u_offset (
		.chroma_blue (cb_s1),
		.chroma_red  (cr_s1),
		.offsets     (offsets)
	);

	// three adders and clamps per pixel, one per colour
	for (genvar p = 0; p < QUAD_N; p++) begin : g_pix
		yqr_pixel u_pixel (
			.luma    (luma_s1[p]),
			.offsets (offsets),
			.rgb     (rgb_next[p])
		);
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rgb_s2 <= rgb_next;
		end
	end

	// output mapping
	assign out_valid          = valid_s2;
	assign red_top_left       = rgb_s2[0].red;
	assign green_top_left     = rgb_s2[0].green;
	assign blue_top_left      = rgb_s2[0].blue;
	assign red_top_right      = rgb_s2[1].red;
	assign green_top_right    = rgb_s2[1].green;
	assign blue_top_right     = rgb_s2[1].blue;
	assign red_bottom_left    = rgb_s2[2].red;
	assign green_bottom_left  = rgb_s2[2].green;
	assign blue_bottom_left   = rgb_s2[2].blue;
	assign red_bottom_right   = rgb_s2[3].red;
	assign green_bottom_right = rgb_s2[3].green;
	assign blue_bottom_right  = rgb_s2[3].blue;

endmodule

### rtl/yqr_offset.sv
module yqr_offset import yqr_pkg::*; (
	input  pix_t     chroma_blue,
	input  pix_t     chroma_red,
	output offsets_t offsets
);

	logic signed [OFFSET_W-1:0] cb;
	logic signed [OFFSET_W-1:0] cr;

	// centering by 128 is a flip of the top bit, then sign extension
	always_comb begin
		cb = OFFSET_W'(signed'({~chroma_blue[PIX_W-1], chroma_blue[PIX_W-2:0]}));
		cr = OFFSET_W'(signed'({~chroma_red[PIX_W-1], chroma_red[PIX_W-2:0]}));
	end

	// shift-add terms, arithmetic shifts floor each term
	always_comb begin
		offsets.red   = cr + (cr >>> 2) + (cr >>> 3) + (cr >>> 5);
		offsets.green = -((cb >>> 2) + (cb >>> 4) + (cb >>> 5))
		              - ((cr >>> 1) + (cr >>> 3) + (cr >>> 4) + (cr >>> 5));
		offsets.blue  = cb + (cb >>> 1) + (cb >>> 2) + (cb >>> 6);
	end

endmodule

### rtl/yqr_pixel.sv
module yqr_pixel import yqr_pkg::*; (
	input  pix_t     luma,
	input  offsets_t offsets,
	output rgb_t     rgb
);

	function automatic pix_t clamp_sum(input pix_t y, input logic signed [OFFSET_W-1:0] off);
		logic signed [SUM_W-1:0] sum;
		sum = signed'(SUM_W'({1'b0, y})) + SUM_W'(off);
		if (sum < 0) begin
			return '0;
		end else if (sum > signed'(SUM_W'(PIXEL_MAX))) begin
			return PIXEL_MAX;
		end
		return sum[PIX_W-1:0];
	endfunction

	// add each offset to the luma and saturate to a byte
	always_comb begin
		rgb.red   = clamp_sum(luma, offsets.red);
		rgb.green = clamp_sum(luma, offsets.green);
		rgb.blue  = clamp_sum(luma, offsets.blue);
	end

endmodule

### rtl/yqr_checker.sv
`include "yuv420_quad_to_rgb888_macros.svh"

module yqr_checker import yqr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input pix_t red_top_left,
	input pix_t green_top_left,
	input pix_t blue_top_left,
	input pix_t red_top_right,
	input pix_t green_top_right,
	input pix_t blue_top_right,
	input pix_t red_bottom_left,
	input pix_t green_bottom_left,
	input pix_t blue_bottom_left,
	input pix_t red_bottom_right,
	input pix_t green_bottom_right,
	input pix_t blue_bottom_right
);

	// an empty result register never pushes back on the input
	`YQR_ASSERT_NOW(a_no_stall_when_empty, clk, arst_n, !out_valid, !in_stall)

	// an open output never pushes back on the input
	`YQR_ASSERT_NOW(a_no_stall_when_open, clk, arst_n, !out_stall, !in_stall)

	// an input transfer reaches the output through both registers when not held
	`YQR_ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && !in_stall) ##1 !out_stall, out_valid)

	// a held result stays offered
	`YQR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// a held result keeps its pixels
	`YQR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall,
		($stable({red_top_left, green_top_left, blue_top_left,
		red_top_right, green_top_right, blue_top_right,
		red_bottom_left, green_bottom_left, blue_bottom_left,
		red_bottom_right, green_bottom_right, blue_bottom_right})))

endmodule

bind yuv420_quad_to_rgb888 yqr_checker u_yqr_checker (.*);
